/* design/vbha_pkg.sv */
// ---------------------------------------------------------------------------
// vbha_pkg
// Shared types, codes and defaults for the voxel box histogram block.
// ---------------------------------------------------------------------------
package vbha_pkg;

    localparam int MAX_DIVISIONS_DEF = 16;
    localparam int COUNT_BITS_DEF    = 16;
    localparam int CFG_AW            = 5;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_DENSE = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    localparam logic [2:0] REG_DIV   = 3'd0;
    localparam logic [2:0] REG_ORG_X = 3'd1;
    localparam logic [2:0] REG_ORG_Y = 3'd2;
    localparam logic [2:0] REG_ORG_Z = 3'd3;
    localparam logic [2:0] REG_CS_X  = 3'd4;
    localparam logic [2:0] REG_CS_Y  = 3'd5;
    localparam logic [2:0] REG_CS_Z  = 3'd6;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] box_min_x;
        logic signed [31:0] box_min_y;
        logic signed [31:0] box_min_z;
        logic signed [31:0] box_max_x;
        logic signed [31:0] box_max_y;
        logic signed [31:0] box_max_z;
        logic [3:0]         read_x;
        logic [3:0]         read_y;
        logic [3:0]         read_z;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        cell_count;
        logic [3:0]         cell_ix;
        logic [3:0]         cell_iy;
        logic [3:0]         cell_iz;
        logic signed [31:0] region_lo_x;
        logic signed [31:0] region_lo_y;
        logic signed [31:0] region_lo_z;
        logic signed [31:0] region_hi_x;
        logic signed [31:0] region_hi_y;
        logic signed [31:0] region_hi_z;
    } t_out_item;

    typedef struct packed {
        logic [4:0]         grid_divisions;
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic [30:0]        cell_size_x;
        logic [30:0]        cell_size_y;
        logic [30:0]        cell_size_z;
    } t_cfg;

endpackage

/* design/voxel_box_histogram_argmax.sv */
// ---------------------------------------------------------------------------
// voxel_box_histogram_argmax
// Occupancy histogram over a cubic voxel grid with densest-cell report.
//
// Input items arrive on a valid/ready channel; read and densest items give
// one result item on the output channel, add and clear items give none.
// Grid setup is written over the APB port while the block is idle: the user
// must keep to this, as the block itself does not enforce it.
// Counts live in one synchronous memory of MAX_DIVISIONS^3 entries.
// Add: a touch test, then six clamped divisions on a shared divider, then
// one cycle per covered cell (read-modify-write pipelined on the memory port).
// Read: memory read, then index scaling, then the output register.
// Densest: one cycle per grid cell. Clear: one cycle per memory entry (4096
// at the defaults), during which no item is taken.
// After reset the same clearing pass runs before the first item is taken.
// A result waits in the output register while the receiver stalls; the next
// item is still taken and processed, and holds before its own result only
// while the output register is full.
// ---------------------------------------------------------------------------
module voxel_box_histogram_argmax #(
    parameter int MAX_DIVISIONS = vbha_pkg::MAX_DIVISIONS_DEF,
    parameter int COUNT_BITS    = vbha_pkg::COUNT_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  vbha_pkg::t_in_item          i_in_item,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output vbha_pkg::t_out_item         o_out_item,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vbha_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    localparam int IW = (MAX_DIVISIONS > 1) ? $clog2(MAX_DIVISIONS) : 1;
    localparam int NC = MAX_DIVISIONS * MAX_DIVISIONS * MAX_DIVISIONS;
    localparam int AW = (NC > 1) ? $clog2(NC) : 1;
    localparam int DW = $clog2(MAX_DIVISIONS + 1);
    localparam int CW = COUNT_BITS;

    localparam logic [3:0] S_CLR    = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_TOUCH  = 4'd2;
    localparam logic [3:0] S_DSTART = 4'd3;
    localparam logic [3:0] S_DWAIT  = 4'd4;
    localparam logic [3:0] S_WINIT  = 4'd5;
    localparam logic [3:0] S_WALK   = 4'd6;
    localparam logic [3:0] S_WDRAIN = 4'd7;
    localparam logic [3:0] S_RD     = 4'd8;
    localparam logic [3:0] S_RDW    = 4'd9;
    localparam logic [3:0] S_SCAN   = 4'd10;
    localparam logic [3:0] S_SDRAIN = 4'd11;
    localparam logic [3:0] S_MUL    = 4'd12;
    localparam logic [3:0] S_PUT    = 4'd13;

    function automatic logic [AW-1:0] f_addr(logic [IW-1:0] x, logic [IW-1:0] y,
                                             logic [IW-1:0] z);
        logic [31:0] t;
        t = (32'(x) * 32'(MAX_DIVISIONS) + 32'(y)) * 32'(MAX_DIVISIONS) + 32'(z);
        return t[AW-1:0];
    endfunction

    vbha_pkg::t_cfg      cfg;
    vbha_pkg::t_in_item  r_item;
    vbha_pkg::t_out_item r_out;

    logic [3:0]    r_state, n_state;
    logic          r_out_valid;
    logic [AW-1:0] r_clr_addr;
    logic [2:0]    r_job;
    logic [IW-1:0] r_lo [3];
    logic [IW-1:0] r_hi [3];
    logic [IW-1:0] r_x, r_y, r_z;
    logic          r_wr_pend;
    logic [AW-1:0] r_wr_addr;
    logic          r_sc_pend;
    logic [IW-1:0] r_sc_idx [3];
    logic [CW-1:0] r_best_cnt;
    logic [IW-1:0] r_best_idx [3];
    logic          r_rd_ok;
    logic [6:0]    r_rep_idx [3];
    logic [31:0]   r_prod [3];
    logic [31:0]   r_span [3];

    logic signed [31:0] org [3];
    logic [30:0]        cs_eff [3];
    logic signed [31:0] bmin [3];
    logic signed [31:0] bmax [3];
    logic [2:0]         touch_ax;
    logic [DW-1:0]      d_eff;
    logic [IW-1:0]      d_m1;
    logic [1:0]         ax;
    logic signed [31:0] corner;
    logic signed [32:0] diff;
    logic               div_done;
    logic [IW-1:0]      div_quot;
    logic               in_fire;
    logic               put_fire;
    logic               walk;
    logic [IW-1:0]      st_lo [3];
    logic [IW-1:0]      st_hi [3];
    logic               last_x, last_y, last_z;
    logic               rd_in_range;
    logic [6:0]         rd_ext [3];
    logic [6:0]         idx_src [3];
    logic               inverted;
    logic [31:0]        cnt_ext;
    logic [31:0]        lo_sum [3];

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [CW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [CW-1:0] mem_rdata;
    logic [CW-1:0] inc;

    vbha_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    vbha_mem #(.DEPTH(NC), .AW(AW), .CW(CW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    vbha_div #(.IW(IW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_DSTART),
        .i_diff  (diff),
        .i_size  (cs_eff[ax]),
        .i_qmax  (d_m1),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        org[0]  = cfg.origin_x;
        org[1]  = cfg.origin_y;
        org[2]  = cfg.origin_z;
        cs_eff[0] = (cfg.cell_size_x == '0) ? 31'd1 : cfg.cell_size_x;
        cs_eff[1] = (cfg.cell_size_y == '0) ? 31'd1 : cfg.cell_size_y;
        cs_eff[2] = (cfg.cell_size_z == '0) ? 31'd1 : cfg.cell_size_z;
        bmin[0] = r_item.box_min_x;
        bmin[1] = r_item.box_min_y;
        bmin[2] = r_item.box_min_z;
        bmax[0] = r_item.box_max_x;
        bmax[1] = r_item.box_max_y;
        bmax[2] = r_item.box_max_z;
        rd_ext[0] = {3'd0, r_item.read_x};
        rd_ext[1] = {3'd0, r_item.read_y};
        rd_ext[2] = {3'd0, r_item.read_z};
    end

    always_comb begin
        if (cfg.grid_divisions == '0) begin
            d_eff = DW'(1);
        end else if (int'(cfg.grid_divisions) > MAX_DIVISIONS) begin
            d_eff = DW'(MAX_DIVISIONS);
        end else begin
            d_eff = DW'(cfg.grid_divisions);
        end
    end
    assign d_m1 = IW'(d_eff - 1'b1);

    always_ff @(posedge i_clk) begin
        for (int a = 0; a < 3; a++) begin
            r_span[a] <= {1'b0, cs_eff[a]} * 32'(d_eff);
        end
    end

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            touch_ax[a] = (bmax[a] >= org[a]) && (bmin[a] <= $signed(org[a] + r_span[a]));
        end
    end

    assign ax     = r_job[2:1];
    assign corner = r_job[0] ? bmax[ax] : bmin[ax];
    assign diff   = {corner[31], corner} - {org[ax][31], org[ax]};

    assign rd_in_range = (int'(r_item.read_x) < MAX_DIVISIONS) &&
                         (int'(r_item.read_y) < MAX_DIVISIONS) &&
                         (int'(r_item.read_z) < MAX_DIVISIONS);

    assign walk = (r_state == S_WALK);
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            st_lo[a] = walk ? r_lo[a] : '0;
            st_hi[a] = walk ? r_hi[a] : d_m1;
        end
    end
    assign last_x = (r_x == st_hi[0]);
    assign last_y = (r_y == st_hi[1]);
    assign last_z = (r_z == st_hi[2]);

    assign inverted = (r_lo[0] > r_hi[0]) || (r_lo[1] > r_hi[1]) || (r_lo[2] > r_hi[2]);

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            idx_src[a] = (r_item.action == vbha_pkg::ACT_DENSE) ? 7'(r_best_idx[a])
                                                               : r_rep_idx[a];
        end
    end

    assign inc       = (mem_rdata == {CW{1'b1}}) ? mem_rdata : mem_rdata + 1'b1;
    assign mem_we    = (r_state == S_CLR) || r_wr_pend;
    assign mem_waddr = (r_state == S_CLR) ? r_clr_addr : r_wr_addr;
    assign mem_wdata = (r_state == S_CLR) ? '0 : inc;

    always_comb begin
        case (r_state)
            S_RD:    mem_raddr = f_addr(rd_ext[0][IW-1:0], rd_ext[1][IW-1:0],
                                        rd_ext[2][IW-1:0]);
            default: mem_raddr = f_addr(r_x, r_y, r_z);
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign put_fire   = (r_state == S_PUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLR:    if (r_clr_addr == AW'(NC - 1)) n_state = S_IDLE;
            S_IDLE: begin
                if (in_fire) begin
                    case (i_in_item.action)
                        vbha_pkg::ACT_ADD:   n_state = S_TOUCH;
                        vbha_pkg::ACT_READ:  n_state = S_RD;
                        vbha_pkg::ACT_DENSE: n_state = S_SCAN;
                        default:             n_state = S_CLR;
                    endcase
                end
            end
            S_TOUCH:  n_state = (&touch_ax) ? S_DSTART : S_IDLE;
            S_DSTART: n_state = S_DWAIT;
            S_DWAIT: begin
                if (div_done) n_state = (r_job == 3'd5) ? S_WINIT : S_DSTART;
            end
            S_WINIT:  n_state = inverted ? S_IDLE : S_WALK;
            S_WALK:   if (last_x && last_y && last_z) n_state = S_WDRAIN;
            S_WDRAIN: n_state = S_IDLE;
            S_RD:     n_state = S_RDW;
            S_RDW:    n_state = S_MUL;
            S_SCAN:   if (last_x && last_y && last_z) n_state = S_SDRAIN;
            S_SDRAIN: n_state = S_MUL;
            S_MUL:    n_state = S_PUT;
            S_PUT:    if (put_fire) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
            r_wr_pend   <= 1'b0;
            r_sc_pend   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_wr_pend <= walk;
            r_sc_pend <= (r_state == S_SCAN);
            if (r_state == S_CLR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end else if (in_fire) begin
                r_clr_addr <= '0;
            end
            if (put_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wr_addr <= f_addr(r_x, r_y, r_z);
        r_sc_idx[0] <= r_x;
        r_sc_idx[1] <= r_y;
        r_sc_idx[2] <= r_z;

        if (in_fire) begin
            r_item     <= i_in_item;
            r_best_cnt <= '0;
            for (int a = 0; a < 3; a++) r_best_idx[a] <= '0;
            r_x <= '0;
            r_y <= '0;
            r_z <= '0;
        end

        if (r_sc_pend && (mem_rdata > r_best_cnt)) begin
            r_best_cnt <= mem_rdata;
            for (int a = 0; a < 3; a++) r_best_idx[a] <= r_sc_idx[a];
        end

        case (r_state)
            S_TOUCH: r_job <= '0;
            S_DWAIT: begin
                if (div_done) begin
                    if (r_job[0]) r_hi[ax] <= div_quot;
                    else          r_lo[ax] <= div_quot;
                    r_job <= r_job + 1'b1;
                end
            end
            S_WINIT: begin
                r_x <= r_lo[0];
                r_y <= r_lo[1];
                r_z <= r_lo[2];
            end
            S_WALK, S_SCAN: begin
                if (!last_z) begin
                    r_z <= r_z + 1'b1;
                end else begin
                    r_z <= st_lo[2];
                    if (!last_y) begin
                        r_y <= r_y + 1'b1;
                    end else begin
                        r_y <= st_lo[1];
                        if (!last_x) r_x <= r_x + 1'b1;
                    end
                end
            end
            S_RD: begin
                r_rd_ok <= rd_in_range;
                for (int a = 0; a < 3; a++) r_rep_idx[a] <= rd_ext[a];
            end
            S_RDW: r_best_cnt <= r_rd_ok ? mem_rdata : '0;
            S_MUL: begin
                for (int a = 0; a < 3; a++) begin
                    r_rep_idx[a] <= idx_src[a];
                    r_prod[a]    <= 32'(idx_src[a]) * {1'b0, cs_eff[a]};
                end
            end
            default: ;
        endcase
    end

    assign cnt_ext = 32'(r_best_cnt);
    always_comb begin
        for (int a = 0; a < 3; a++) begin
            lo_sum[a] = org[a] + r_prod[a];
        end
    end

    always_ff @(posedge i_clk) begin
        if (put_fire) begin
            r_out.cell_count  <= cnt_ext[15:0];
            r_out.cell_ix     <= r_rep_idx[0][3:0];
            r_out.cell_iy     <= r_rep_idx[1][3:0];
            r_out.cell_iz     <= r_rep_idx[2][3:0];
            r_out.region_lo_x <= lo_sum[0];
            r_out.region_lo_y <= lo_sum[1];
            r_out.region_lo_z <= lo_sum[2];
            r_out.region_hi_x <= lo_sum[0] + {1'b0, cs_eff[0]};
            r_out.region_hi_y <= lo_sum[1] + {1'b0, cs_eff[1]};
            r_out.region_hi_z <= lo_sum[2] + {1'b0, cs_eff[2]};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

/* design/vbha_mem.sv */
// ---------------------------------------------------------------------------
// vbha_mem
// Cell count memory, one write port and one registered read port.
// ---------------------------------------------------------------------------
module vbha_mem #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12,
    parameter int CW    = 16
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [CW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [CW-1:0] o_rdata
);

    logic [CW-1:0] r_mem [DEPTH];
    logic [CW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/vbha_div.sv */
// ---------------------------------------------------------------------------
// vbha_div
// Clamped cell index divider: one quotient bit per cycle, saturating early.
// ---------------------------------------------------------------------------
module vbha_div #(
    parameter int IW = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic signed [32:0] i_diff,
    input  logic [30:0]       i_size,
    input  logic [IW-1:0]     i_qmax,
    output logic              o_done,
    output logic [IW-1:0]     o_quot
);

    localparam int SW = $clog2(IW + 1);

    logic          r_busy;
    logic          r_done;
    logic [SW-1:0] r_step;
    logic [31:0]   r_rem;
    logic [IW-1:0] r_q;
    logic [IW-1:0] r_quot;

    logic [39:0]   shifted;
    logic          ge;
    logic [IW-1:0] q_new;
    logic [IW-1:0] q_clamp;

    assign shifted = {9'd0, i_size} << r_step;
    assign ge      = {8'd0, r_rem} >= shifted;
    assign q_new   = ge ? (r_q | (IW'(1) << r_step)) : r_q;
    assign q_clamp = (q_new > i_qmax) ? i_qmax : q_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (i_diff[32]) begin
                    r_quot <= '0;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= i_diff[31:0];
                    r_step <= SW'(IW);
                    r_q    <= '0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                if (r_step == SW'(IW)) begin
                    if (ge) begin
                        r_quot <= i_qmax;
                        r_done <= 1'b1;
                        r_busy <= 1'b0;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end else begin
                    if (ge) begin
                        r_rem <= r_rem - shifted[31:0];
                    end
                    r_q <= q_new;
                    if (r_step == '0) begin
                        r_quot <= q_clamp;
                        r_done <= 1'b1;
                        r_busy <= 1'b0;
                    end else begin
                        r_step <= r_step - 1'b1;
                    end
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

/* design/vbha_cfg.sv */
// ---------------------------------------------------------------------------
// vbha_cfg
// APB register file for grid divisions, origin and cell size.
// ---------------------------------------------------------------------------
module vbha_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [vbha_pkg::CFG_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output vbha_pkg::t_cfg             o_cfg
);

    vbha_pkg::t_cfg r_cfg;
    logic [2:0]     reg_idx;

    assign reg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_divisions <= 5'd1;
            r_cfg.origin_x       <= '0;
            r_cfg.origin_y       <= '0;
            r_cfg.origin_z       <= '0;
            r_cfg.cell_size_x    <= 31'd65536;
            r_cfg.cell_size_y    <= 31'd65536;
            r_cfg.cell_size_z    <= 31'd65536;
        end else if (psel && penable && pwrite && (paddr[1:0] == 2'b00)) begin
            case (reg_idx)
                vbha_pkg::REG_DIV:   r_cfg.grid_divisions <= pwdata[4:0];
                vbha_pkg::REG_ORG_X: r_cfg.origin_x       <= pwdata;
                vbha_pkg::REG_ORG_Y: r_cfg.origin_y       <= pwdata;
                vbha_pkg::REG_ORG_Z: r_cfg.origin_z       <= pwdata;
                vbha_pkg::REG_CS_X:  r_cfg.cell_size_x    <= pwdata[30:0];
                vbha_pkg::REG_CS_Y:  r_cfg.cell_size_y    <= pwdata[30:0];
                vbha_pkg::REG_CS_Z:  r_cfg.cell_size_z    <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[1:0] == 2'b00) begin
            case (reg_idx)
                vbha_pkg::REG_DIV:   prdata = {27'd0, r_cfg.grid_divisions};
                vbha_pkg::REG_ORG_X: prdata = r_cfg.origin_x;
                vbha_pkg::REG_ORG_Y: prdata = r_cfg.origin_y;
                vbha_pkg::REG_ORG_Z: prdata = r_cfg.origin_z;
                vbha_pkg::REG_CS_X:  prdata = {1'b0, r_cfg.cell_size_x};
                vbha_pkg::REG_CS_Y:  prdata = {1'b0, r_cfg.cell_size_y};
                vbha_pkg::REG_CS_Z:  prdata = {1'b0, r_cfg.cell_size_z};
                default:             prdata = '0;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
